### src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define EFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define EFC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### src/efc_pkg.sv
`default_nettype none
package efc_pkg;

	localparam int HDR_LEN     = 6;
	localparam int OVERHEAD    = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [3:0]  NIBBLE_MASK = 4'h F;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_LONG    = 3'd2,
		ST_CRC     = 3'd3,
		ST_LENGTH  = 3'd4,
		ST_VERSION = 3'd5,
		ST_TYPE    = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] payload_byte;
		logic [2:0] status;
		logic [3:0] frame_version;
		logic [3:0] msg_type;
		logic [7:0] source;
		logic [7:0] dest;
		logic [7:0] language;
		logic [7:0] sequence_res;
		logic [7:0] payload_length;
		logic       final_item;
	} out_t;

	// one queue entry: the results caused by one input beat
	typedef struct packed {
		logic       has_payload;
		logic [7:0] payload_byte;
		logic       has_status;
		status_t    status;
		logic [3:0] frame_version;
		logic [3:0] msg_type;
		logic [7:0] source;
		logic [7:0] dest;
		logic [7:0] language;
		logic [7:0] sequence_res;
		logic [7:0] payload_length;
	} entry_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} q_stat_t;

	// bytewise crc-16/ccitt-false update, msb first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### src/efc_front.sv
`default_nettype none
module efc_front #(
	parameter int MAX_FRAME = 255
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire efc_pkg::in_t   in_data,
	output logic                in_stall,
	input  wire logic [3:0]     expected_version,
	input  wire logic [3:0]     highest_type,
	input  wire efc_pkg::q_stat_t qstat,
	output logic                push,
	output efc_pkg::entry_t     push_entry
);

	localparam int CntW = $clog2(MAX_FRAME + 2);
	localparam logic [CntW-1:0] CntSat = CntW'(MAX_FRAME + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME);

	logic [CntW-1:0] count_q;
	logic [15:0]     crc_q;
	logic [7:0]      dly0_q;
	logic [7:0]      dly1_q;
	logic [7:0]      hdr_q [efc_pkg::HDR_LEN];

	logic            accept;
	logic            has_payload;
	logic [CntW-1:0] count_next;
	logic [15:0]     crc_cur;
	logic [15:0]     want;
	efc_pkg::status_t st;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;

	always_comb begin
		has_payload = count_q >= CntW'(efc_pkg::OVERHEAD);
		count_next  = (count_q < CntSat) ? count_q + CntW'(1) : count_q;
		crc_cur     = (count_q >= CntW'(2)) ? efc_pkg::crc_update(crc_q, dly0_q) : crc_q;
		want        = {dly1_q, in_data.data_byte};

		// first error wins
		priority if (count_next < CntW'(efc_pkg::OVERHEAD)) begin
			st = efc_pkg::ST_SHORT;
		end else if (count_next > CntMax) begin
			st = efc_pkg::ST_LONG;
		end else if (crc_cur != want) begin
			st = efc_pkg::ST_CRC;
		end else if (10'(hdr_q[5]) + 10'(efc_pkg::OVERHEAD) != 10'(count_next)) begin
			st = efc_pkg::ST_LENGTH;
		end else if (hdr_q[0][7:4] != expected_version) begin
			st = efc_pkg::ST_VERSION;
		end else if ((hdr_q[0][3:0] & efc_pkg::NIBBLE_MASK) > highest_type) begin
			st = efc_pkg::ST_TYPE;
		end else begin
			st = efc_pkg::ST_OK;
		end

		push                     = accept && (has_payload || in_data.end_of_frame);
		push_entry               = '0;
		push_entry.has_payload   = has_payload;
		push_entry.payload_byte  = has_payload ? dly0_q : 8'h00;
		push_entry.has_status    = in_data.end_of_frame;
		push_entry.status        = in_data.end_of_frame ? st : efc_pkg::ST_OK;
		if (in_data.end_of_frame && st == efc_pkg::ST_OK) begin
			push_entry.frame_version  = hdr_q[0][7:4];
			push_entry.msg_type       = hdr_q[0][3:0];
			push_entry.source         = hdr_q[1];
			push_entry.dest           = hdr_q[2];
			push_entry.language       = hdr_q[3];
			push_entry.sequence_res   = hdr_q[4];
			push_entry.payload_length = hdr_q[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= efc_pkg::CRC_INIT;
			dly0_q  <= '0;
			dly1_q  <= '0;
			for (int i = 0; i < efc_pkg::HDR_LEN; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (accept) begin
			if (in_data.end_of_frame) begin
				count_q <= '0;
				crc_q   <= efc_pkg::CRC_INIT;
				dly0_q  <= '0;
				dly1_q  <= '0;
				for (int i = 0; i < efc_pkg::HDR_LEN; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				count_q <= count_next;
				crc_q   <= crc_cur;
				dly0_q  <= dly1_q;
				dly1_q  <= in_data.data_byte;
				for (int i = 0; i < efc_pkg::HDR_LEN; i++) begin
					if (count_q == CntW'(i)) begin
						hdr_q[i] <= in_data.data_byte;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### src/efc_queue.sv
`default_nettype none
module efc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire efc_pkg::entry_t  push_entry,
	input  wire logic             pop,
	output efc_pkg::entry_t       head,
	output efc_pkg::q_stat_t      qstat
);

	`include "assert_macros.svh"

	localparam int Depth = efc_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	efc_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head             = mem_q[rd_ptr_q];
	assign qstat.head_valid = count_q != '0;
	assign qstat.full       = count_q == CntW'(Depth);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`EFC_NEVER(a_push_full, push && qstat.full && !pop, "push into full queue")
	`EFC_ASSERT(a_count_range, count_q <= CntW'(Depth), "queue count beyond depth")

endmodule
`default_nettype wire

### src/efc_back.sv
`default_nettype none
module efc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire efc_pkg::entry_t  head,
	input  wire efc_pkg::q_stat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output efc_pkg::out_t         out_data
);

	`include "assert_macros.svh"

	logic           out_valid_q;
	efc_pkg::out_t  out_q;
	logic           phase_q;   // payload of head already sent, status pending
	logic           load;
	logic           send_payload;
	efc_pkg::out_t  beat;

	always_comb begin
		send_payload = head.has_payload && !phase_q;
		load         = qstat.head_valid && (!out_valid_q || !out_stall);
		pop          = load && !(send_payload && head.has_status);
		beat         = '0;
		if (send_payload) begin
			beat.payload_byte = head.payload_byte;
		end else begin
			beat.item_kind      = 1'b1;
			beat.status         = head.status;
			beat.frame_version  = head.frame_version;
			beat.msg_type       = head.msg_type;
			beat.source         = head.source;
			beat.dest           = head.dest;
			beat.language       = head.language;
			beat.sequence_res   = head.sequence_res;
			beat.payload_length = head.payload_length;
			beat.final_item     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !pop;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`EFC_ASSERT(a_pop_has_head, pop |-> qstat.head_valid, "pop from empty queue")
	`EFC_ASSERT(a_phase_pending, phase_q |-> qstat.head_valid && head.has_status, "status lost after payload")
	`EFC_ASSERT(a_err_no_hdr, out_valid_q && out_q.item_kind && out_q.status != efc_pkg::ST_OK |-> out_q.source == 8'h00 && out_q.payload_length == 8'h00, "header leaked on error")

endmodule
`default_nettype wire

### src/envelope_frame_checker_core.sv
`default_nettype none
// channel | direction | handshake           | beat
// in      | input     | in_valid / in_stall   | in_data : one frame byte plus end flag
// out     | output    | out_valid / out_stall | out_data: payload byte or frame status
// cfg     | input     | apb psel/penable      | expected_version, highest_type
//
// one byte a cycle sustained while out_stall stays low: the front does the crc byte update,
// counter and header capture in the same cycle, the back sends one beat a cycle from the queue
// a byte that ends a frame with payload gives two beats, its payload beat then its status beat
// an accepted byte's entry is registered in the queue, then its beat in the output register
// reset clears the frame state, the queue pointers and the output valid flag; registers
// go to expected_version 1, highest_type 15
// in_stall rises only when the two-entry queue is full; out_stall holds the beat
module envelope_frame_checker_core #(
	parameter int MAX_FRAME = 255
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// byte input
	input  wire logic          in_valid,
	input  wire efc_pkg::in_t  in_data,
	output logic               in_stall,
	// result output
	output logic               out_valid,
	input  wire logic          out_stall,
	output efc_pkg::out_t      out_data,
	// configuration
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// register index is the word address
	localparam logic REG_EXPECTED_VERSION = 1'b0;
	localparam logic REG_HIGHEST_TYPE     = 1'b1;

	logic [3:0] expected_version_q;
	logic [3:0] highest_type_q;
	logic       cfg_write;

	logic             push;
	logic             pop;
	efc_pkg::entry_t  push_entry;
	efc_pkg::entry_t  head;
	efc_pkg::q_stat_t qstat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// registers, upper data bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_version_q <= 4'd1;
			highest_type_q     <= 4'd15;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_EXPECTED_VERSION: expected_version_q <= pwdata[3:0];
				REG_HIGHEST_TYPE:     highest_type_q     <= pwdata[3:0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EXPECTED_VERSION: prdata = {28'd0, expected_version_q};
			REG_HIGHEST_TYPE:     prdata = {28'd0, highest_type_q};
			default:              prdata = '0;
		endcase
	end

	// front: count, delay line, crc and status decision
	efc_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_data          (in_data),
		.in_stall         (in_stall),
		.expected_version (expected_version_q),
		.highest_type     (highest_type_q),
		.qstat            (qstat),
		.push             (push),
		.push_entry       (push_entry)
	);

	// short queue decoupling front and back
	efc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// back: splits entries into beats behind an output register
	efc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
